@@ rtl/core/suffix_masked_address_filter_unit_assert.svh @@
// Assertion macros for the suffix masked address filter.
// Included by modules that check their own control logic; needs i_clk and i_rst_n.
`ifndef SUFFIX_MASKED_ADDRESS_FILTER_UNIT_ASSERT_SVH
`define SUFFIX_MASKED_ADDRESS_FILTER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SMAF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SMAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/smaf_pkg.sv @@
// Package for the suffix masked address filter: request/response types,
// status codes, table sizing and the suffix mask function. No dependencies.
package smaf_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic       OP_ADD   = 1'b0;
    localparam logic       OP_CHECK = 1'b1;

    localparam logic [2:0] ST_ADDED      = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_LEAVE      = 3'd2;
    localparam logic [2:0] ST_SUPPRESSED = 3'd3;
    localparam logic [2:0] ST_UNKNOWN    = 3'd4;

    localparam logic [3:0] MAX_BYTES = 4'd8;

    typedef struct packed {
        logic        opcode;
        logic [63:0] ext_addr;
        logic [3:0]  match_bytes;
        logic [15:0] short_addr;
        logic        addr_known;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] leave_addr;
    } t_rsp;

    typedef struct packed {
        logic [63:0] addr;
        logic [3:0]  len;
    } t_entry;

    // result handed from the sequencer to the output stage
    typedef struct packed {
        logic valid;
        t_rsp data;
    } t_rsp_bus;

    // high n bytes set; n above 8 acts as 8
    function automatic logic [63:0] suffix_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if ((n >= MAX_BYTES) || ({28'd0, n} + i >= 8)) begin
                m[8*i +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

@@ rtl/core/smaf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module smaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/smaf_ctrl.sv @@
// Sequencer for the filter: appends entries to the table RAM and walks it
// one entry per cycle on a check. Depends on smaf_pkg, smaf_ram and the assert header.
`include "suffix_masked_address_filter_unit_assert.svh"

module smaf_ctrl
    import smaf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  t_req     i_req,
    output logic     o_req_stall,
    output t_rsp_bus o_res,
    input  logic     i_res_take
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_RES  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [63:0]      r_ext, n_ext;
    logic [15:0]      r_saddr, n_saddr;
    t_rsp             r_res, n_res;

    logic       accept;
    logic       ram_we;
    logic       ram_re;
    logic [IDX_W-1:0] ram_raddr;
    t_entry     wr_entry;
    t_entry     rd_entry;
    logic       hit;
    logic       last;

    assign accept      = i_req_valid && (r_state == S_IDLE);
    assign o_req_stall = (r_state != S_IDLE);

    assign wr_entry.addr = i_req.ext_addr;
    assign wr_entry.len  = (i_req.match_bytes > MAX_BYTES) ? MAX_BYTES : i_req.match_bytes;

    assign hit  = ((rd_entry.addr ^ r_ext) & suffix_mask(rd_entry.len)) == 64'd0;
    assign last = ({1'b0, r_rd_idx} == CNT_W'(r_cnt - CNT_W'(1)));

    smaf_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[IDX_W-1:0]),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_entry)
    );

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_rd_idx  = r_rd_idx;
        n_ext     = r_ext;
        n_saddr   = r_saddr;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ext   = i_req.ext_addr;
                    n_saddr = i_req.short_addr;
                    n_res.leave_addr = 16'd0;
                    n_state = S_RES;
                    if (i_req.opcode == OP_ADD) begin
                        if (r_cnt == CNT_W'(TABLE_DEPTH)) begin
                            n_res.status = ST_FULL;
                        end else begin
                            ram_we       = 1'b1;
                            n_cnt        = r_cnt + CNT_W'(1);
                            n_res.status = ST_ADDED;
                        end
                    end else if (!i_req.addr_known) begin
                        n_res.status = ST_UNKNOWN;
                    end else if (r_cnt == '0) begin
                        n_res.status     = ST_LEAVE;
                        n_res.leave_addr = i_req.short_addr;
                    end else begin
                        // first entry read issued now, data arrives in the walk
                        ram_re   = 1'b1;
                        n_rd_idx = '0;
                        n_state  = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (hit) begin
                    n_res.status     = ST_SUPPRESSED;
                    n_res.leave_addr = 16'd0;
                    n_state          = S_RES;
                end else if (last) begin
                    n_res.status     = ST_LEAVE;
                    n_res.leave_addr = r_saddr;
                    n_state          = S_RES;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_rd_idx + IDX_W'(1);
                    n_rd_idx  = r_rd_idx + IDX_W'(1);
                end
            end
            S_RES: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_rd_idx <= n_rd_idx;
        r_ext    <= n_ext;
        r_saddr  <= n_saddr;
        r_res    <= n_res;
    end

    assign o_res.valid = (r_state == S_RES);
    assign o_res.data  = r_res;

    `SMAF_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CNT_W'(TABLE_DEPTH), "entry count above depth")
    `SMAF_ASSERT_NOW(a_walk_in_range, r_state == S_WALK, {1'b0, r_rd_idx} < r_cnt, "walk past last entry")
    `SMAF_ASSERT_NOW(a_write_on_add, ram_we, accept && (i_req.opcode == OP_ADD), "table write without add")
    `SMAF_ASSERT_NEXT(a_full_holds, accept && (i_req.opcode == OP_ADD) && (r_cnt == CNT_W'(TABLE_DEPTH)), $stable(r_cnt), "full add changed count")

endmodule

@@ rtl/core/suffix_masked_address_filter_unit.sv @@
// Suffix masked address filter, top level: request/response ports and the
// response register. Depends on smaf_pkg and smaf_ctrl.
//
// Usage:
//   Request channel (i_valid / o_stall, payload i_req): an add appends
//   ext_addr with its trailing byte count to the table; a check reports
//   unknown, suppressed or send-leave for a short address.
//   Response channel (o_valid / i_stall, payload o_rsp): one response per
//   request, in request order.
//   Timing: an add or an unknown-address check passes from the sequencer's
//   result register into the response register, and the next request is taken once the sequencer has handed it on.
//   A check that walks the stored entries reads one table RAM entry per
//   cycle and stops at the first match, so its cost grows with the number
//   of entries walked, up to a full table of 64 entries.
//   Reset (synchronous, active low) empties the table; stored entries
//   are not cleared, the fill count is.
//   When i_stall holds the response, the response register keeps it and
//   one more request can be accepted and finished into the sequencer
//   behind it; further requests stall until the response register drains.
module suffix_masked_address_filter_unit
    import smaf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    t_rsp_bus res;
    logic     take;
    logic     r_out_valid;
    t_rsp     r_out;

    smaf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .i_req       (i_req),
        .o_req_stall (o_stall),
        .o_res       (res),
        .i_res_take  (take)
    );

    // register is free when empty or being drained this cycle
    assign take = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res.valid;
        end
        if (take && res.valid) begin
            r_out <= res.data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

@@ dv/smaf_leave_checker.sv @@
`timescale 1ns / 1ps
// Response checker for the suffix masked address filter: keeps its own copy of the
// table, predicts each response and compares in order. Depends on smaf_pkg.
module smaf_leave_checker
    import smaf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_stall,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_stall,
    input  t_rsp i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    logic [63:0] shadow_addr [TABLE_DEPTH];
    logic [3:0]  shadow_len  [TABLE_DEPTH];
    int          shadow_count = 0;
    t_rsp        leave_verdict_q [$];
    t_rsp        want;
    int          fail_count = 0;
    int          pending_n = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_n;

    // high nbytes bytes of the word; nbytes is already limited to 8
    function automatic logic [63:0] tail_mask(input logic [3:0] nbytes);
        if (nbytes == 4'd0) begin
            return 64'd0;
        end
        return ~64'd0 << (8 * (8 - nbytes));
    endfunction

    // updates the shadow table and returns the response the block owes
    function automatic t_rsp apply_filter_request(input t_req r);
        t_rsp res;
        logic hit;
        res = '0;
        if (r.opcode == OP_ADD) begin
            if (shadow_count >= TABLE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                shadow_addr[shadow_count] = r.ext_addr;
                shadow_len[shadow_count]  = (r.match_bytes > MAX_BYTES) ? MAX_BYTES
                                                                       : r.match_bytes;
                shadow_count++;
                res.status = ST_ADDED;
            end
        end else if (!r.addr_known) begin
            res.status = ST_UNKNOWN;
        end else begin
            hit = 1'b0;
            for (int k = 0; k < shadow_count; k++) begin
                if (((shadow_addr[k] ^ r.ext_addr) & tail_mask(shadow_len[k])) == 64'd0) begin
                    hit = 1'b1;
                end
            end
            if (hit) begin
                res.status = ST_SUPPRESSED;
            end else begin
                res.status     = ST_LEAVE;
                res.leave_addr = r.short_addr;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            leave_verdict_q.delete();
        end else begin
            // older responses first; a request cannot answer in its own cycle
            if (i_rsp_valid === 1'b1 && i_rsp_stall === 1'b0) begin
                if (leave_verdict_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected response: status %0d leave %h",
                                 i_rsp.status, i_rsp.leave_addr);
                    end
                end else begin
                    want = leave_verdict_q.pop_front();
                    if (i_rsp.status !== want.status || i_rsp.leave_addr !== want.leave_addr) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("response mismatch: expected status %0d leave %h, got status %0d leave %h",
                                     want.status, want.leave_addr, i_rsp.status, i_rsp.leave_addr);
                        end
                    end
                end
            end
            if (i_req_valid === 1'b1 && i_req_stall === 1'b0) begin
                leave_verdict_q.push_back(apply_filter_request(i_req));
            end
            pending_n = leave_verdict_q.size();
        end
    end

endmodule

@@ dv/tb_suffix_masked_address_filter_unit.sv @@
`timescale 1ns / 1ps
// Testbench top for the suffix masked address filter: clock, reset, request and
// response-side traffic, verdict. Depends on smaf_pkg, the block and smaf_leave_checker.
module tb_suffix_masked_address_filter_unit;
    import smaf_pkg::*;

    localparam int CYCLE_LIMIT       = 1000000;
    localparam int RANDOM_FILL_ITEMS = 1500;
    localparam int RANDOM_TAIL_ITEMS = 360;
    localparam int DRAIN_CYCLES      = 70;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_req i_req   = '0;
    logic o_stall;
    logic o_valid;
    t_rsp o_rsp;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // what the table has accepted, in order (raw byte counts)
    logic [63:0] sent_addr [$];
    logic [3:0]  sent_len  [$];
    int n_add = 0;
    int n_full = 0;
    int n_check = 0;
    int n_unknown = 0;

    int src_burst = 0;
    int sink_burst = 0;
    int sink_draw;
    int stall_left = 0;

    always #10 i_clk = ~i_clk;

    suffix_masked_address_filter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    smaf_leave_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_req        (i_req),
        .i_rsp_valid  (o_valid),
        .i_rsp_stall  (i_stall),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[suffix_masked_address_filter_unit] ERROR");
            $finish;
        end
    end

    // response side: a fresh stall draw after each taken response; the count
    // mostly runs down while a response waits so the hold lands on it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (o_valid === 1'b1 && !i_stall) begin
            if ($urandom_range(0, 63) == 0) begin
                sink_burst = !sink_burst;
            end
            sink_draw = sink_burst ? 0 : $urandom_range(0, 5);
            stall_left <= sink_draw;
            i_stall    <= (sink_draw != 0);
        end else if (stall_left != 0 && (o_valid === 1'b1 || $urandom_range(0, 1) == 1)) begin
            stall_left <= stall_left - 1;
            i_stall    <= (stall_left > 1);
        end
    end

    function automatic t_req random_request();
        t_req r;
        r.opcode      = 1'($urandom_range(0, 1));
        r.ext_addr    = {$urandom, $urandom};
        r.match_bytes = 4'($urandom_range(0, 15));
        r.short_addr  = 16'($urandom_range(0, 65535));
        r.addr_known  = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic push_request(input t_req r);
        int gap;
        if ($urandom_range(0, 63) == 0) begin
            src_burst = !src_burst;
        end
        gap = src_burst ? 0 : $urandom_range(0, 5);
        if (r.opcode == OP_ADD) begin
            n_add++;
            if (sent_addr.size() < TABLE_DEPTH) begin
                sent_addr.push_back(r.ext_addr);
                sent_len.push_back(r.match_bytes);
            end else begin
                n_full++;
            end
        end else begin
            n_check++;
            if (!r.addr_known) begin
                n_unknown++;
            end
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    task automatic send_add(input logic [63:0] addr, input logic [3:0] nbytes);
        t_req r;
        r = random_request();
        r.opcode      = OP_ADD;
        r.ext_addr    = addr;
        r.match_bytes = nbytes;
        push_request(r);
    endtask

    task automatic send_check(input logic [63:0] addr, input logic [15:0] saddr,
                              input logic known);
        t_req r;
        r = random_request();
        r.opcode     = OP_CHECK;
        r.ext_addr   = addr;
        r.short_addr = saddr;
        r.addr_known = known;
        push_request(r);
    endtask

    task automatic random_add();
        t_req r;
        r = random_request();
        r.opcode      = OP_ADD;
        r.match_bytes = 4'($urandom_range(1, 15));
        push_request(r);
    endtask

    // half the checks aim at a stored entry: exact, same suffix with other
    // leading bytes, or one bit off inside the compared bytes
    task automatic random_check();
        t_req        r;
        int          k;
        int          keep;
        logic [63:0] m;
        r = random_request();
        r.opcode     = OP_CHECK;
        r.addr_known = ($urandom_range(0, 7) != 0);
        if (sent_addr.size() > 0 && $urandom_range(0, 1) == 1) begin
            k    = $urandom_range(0, sent_addr.size() - 1);
            keep = (sent_len[k] > 4'd8) ? 8 : int'(sent_len[k]);
            m    = (keep == 0) ? 64'd0 : ~64'd0 << (8 * (8 - keep));
            case ($urandom_range(0, 2))
                0: begin
                    r.ext_addr = sent_addr[k];
                end
                1: begin
                    r.ext_addr = (sent_addr[k] & m) | (r.ext_addr & ~m);
                end
                default: begin
                    if (keep > 0) begin
                        r.ext_addr = sent_addr[k] ^ (64'd1 << $urandom_range(64 - 8 * keep, 63));
                    end
                end
            endcase
        end
        push_request(r);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: unknown, then leave at both ends of the short address
        send_check(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b0);
        send_check(64'h0000_0000_0000_0000, 16'h0000, 1'b1);
        send_check(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
        // full-length compare
        send_add(64'h0123_4567_89AB_CDEF, 4'd8);
        send_check(64'h0123_4567_89AB_CDEF, 16'h1234, 1'b1);
        send_check(64'h0123_4567_89AB_CDEE, 16'h5678, 1'b1);
        // counts above 8 act as 8
        send_add(64'hA5A5_A5A5_5A5A_5A5A, 4'd15);
        send_check(64'hA5A5_A5A5_5A5A_5A5B, 16'h8001, 1'b1);
        send_check(64'hA5A5_A5A5_5A5A_5A5A, 16'h7FFE, 1'b1);
        send_add(64'h8000_0000_0000_0001, 4'd9);
        send_check(64'h8000_0000_0000_0000, 16'hAAAA, 1'b1);
        send_check(64'h8000_0000_0000_0001, 16'h5555, 1'b1);
        // partial suffixes
        send_add(64'hBEEF_0000_0000_0000, 4'd2);
        send_check(64'hBEEF_1234_5678_9ABC, 16'h0001, 1'b1);
        send_check(64'hBEEE_1234_5678_9ABC, 16'h0002, 1'b1);
        send_add(64'h7700_0000_0000_0000, 4'd1);
        send_check(64'h77FF_FFFF_FFFF_FFFF, 16'h0003, 1'b1);
        send_check(64'h7600_0000_0000_0000, 16'h0004, 1'b1);
        send_add(64'h1234_5678_0000_0000, 4'd4);
        send_check(64'h1234_5678_FFFF_FFFF, 16'h0005, 1'b1);
        send_check(64'h1234_5679_FFFF_FFFF, 16'h0006, 1'b1);
        // unknown wins even over a matching entry
        send_check(64'h0123_4567_89AB_CDEF, 16'hFFFF, 1'b0);

        for (int i = 0; i < RANDOM_FILL_ITEMS; i++) begin
            if (sent_addr.size() < TABLE_DEPTH - 1 && $urandom_range(0, 21) == 0) begin
                random_add();
            end else begin
                random_check();
            end
        end
        while (sent_addr.size() < TABLE_DEPTH - 1) begin
            random_add();
        end
        // zero-length entry takes the last slot: every known address hits it
        send_add({$urandom, $urandom}, 4'd0);
        for (int i = 0; i < RANDOM_TAIL_ITEMS; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                random_add();
            end else begin
                random_check();
            end
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("requests: %0d adds (%0d refused on a full table), %0d checks (%0d unknown)",
                 n_add, n_full, n_check, n_unknown);
        $display("table filled to %0d entries, the last a zero-length wildcard", sent_addr.size());
        if (fail_count == 0 && pending == 0) begin
            $display("[suffix_masked_address_filter_unit] OK");
        end else begin
            $display("[suffix_masked_address_filter_unit] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/smaf_pkg.sv
rtl/core/smaf_ram.sv
rtl/core/smaf_ctrl.sv
rtl/core/suffix_masked_address_filter_unit.sv
dv/smaf_leave_checker.sv
dv/tb_suffix_masked_address_filter_unit.sv
